// ===== hw/rtl/rarmb_pkg.sv =====
// Package: shared constants, opcode and state types, and controller/datapath command and status types.
package rarmb_pkg;

  localparam int unsigned NumElementsDefault = 1024;
  localparam int unsigned BlockLenDefault    = 32;
  localparam int unsigned NumBlocksDefault   = 32;

  localparam int unsigned IdxW   = 10;
  localparam int unsigned ValW   = 64;
  localparam int unsigned OperW  = 35;
  localparam logic [ValW-1:0] QueryStart = 64'd10000000000000000;

  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpAdd   = 2'd1,
    OpQuery = 2'd2,
    OpNone  = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StBlock,
    StScanRd,
    StScanWait,
    StScanDo,
    StMinRd,
    StMinWait,
    StMinDo,
    StMinStore,
    StResult
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic clr_step;     // write zero at clear address, advance clear address
    logic capture;      // latch input item and set up block walk
    logic blk_whole;    // apply whole-block action at current block
    logic blk_part;     // prepare partial scan of current block
    logic blk_next;     // advance to next block
    logic scan_rd;      // issue element read at scan address
    logic scan_do;      // apply element action, advance scan address
    logic min_start;    // prepare min recompute over current block
    logic min_rd;       // issue element read at min address
    logic min_do;       // fold element into running min, advance
    logic min_store;    // write block minimum
    logic load_write;   // write loaded element
    logic res_clear;    // reset running query minimum
    logic res_load;     // copy finished query minimum into output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_done;
    logic op_valid;     // item has a non-empty in-range effect
    logic blk_is_whole;
    logic blk_last;
    logic scan_last;
    logic min_last;
  } sts_t;

endpackage

// ===== hw/rtl/rarmb_ctrl.sv =====
// Controller: sequences clearing, block walks, element scans and recomputes.
module rarmb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       opcode_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  rarmb_pkg::sts_t  sts_i,
  output rarmb_pkg::cmd_t  cmd_o
);

  rarmb_pkg::state_e state_q, state_d;
  rarmb_pkg::opcode_e op_q, op_d;
  logic out_full_q, out_full_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rarmb_pkg::StClear;
      op_q       <= rarmb_pkg::OpNone;
      out_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      out_full_q <= out_full_d;
    end
  end

  // Output register: fill on handover, drain when taken.
  assign out_full_d  = (out_full_q && !out_ready_i) || cmd_o.res_load;
  assign out_valid_o = out_full_q;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      rarmb_pkg::StClear: begin
        if (sts_i.clr_done) state_d = rarmb_pkg::StIdle;
      end
      rarmb_pkg::StIdle: begin
        if (in_valid_i) begin
          op_d = rarmb_pkg::opcode_e'(opcode_i);
          case (rarmb_pkg::opcode_e'(opcode_i))
            rarmb_pkg::OpLoad:  state_d = rarmb_pkg::StBlock;
            rarmb_pkg::OpAdd:   state_d = rarmb_pkg::StBlock;
            rarmb_pkg::OpQuery: state_d = rarmb_pkg::StBlock;
            default:            state_d = rarmb_pkg::StIdle;
          endcase
        end
      end
      rarmb_pkg::StBlock: begin
        if (!sts_i.op_valid) begin
          state_d = (op_q == rarmb_pkg::OpQuery) ? rarmb_pkg::StResult : rarmb_pkg::StIdle;
        end else if (op_q == rarmb_pkg::OpLoad) begin
          state_d = rarmb_pkg::StMinRd;
        end else if (sts_i.blk_is_whole) begin
          if (sts_i.blk_last) begin
            state_d = (op_q == rarmb_pkg::OpQuery) ? rarmb_pkg::StResult
                                                   : rarmb_pkg::StIdle;
          end
        end else begin
          state_d = rarmb_pkg::StScanRd;
        end
      end
      rarmb_pkg::StScanRd:   state_d = rarmb_pkg::StScanWait;
      rarmb_pkg::StScanWait: state_d = rarmb_pkg::StScanDo;
      rarmb_pkg::StScanDo: begin
        if (!sts_i.scan_last) begin
          state_d = rarmb_pkg::StScanRd;
        end else if (op_q == rarmb_pkg::OpAdd) begin
          state_d = rarmb_pkg::StMinRd;
        end else if (sts_i.blk_last) begin
          state_d = rarmb_pkg::StResult;
        end else begin
          state_d = rarmb_pkg::StBlock;
        end
      end
      rarmb_pkg::StMinRd:   state_d = rarmb_pkg::StMinWait;
      rarmb_pkg::StMinWait: state_d = rarmb_pkg::StMinDo;
      rarmb_pkg::StMinDo: begin
        state_d = sts_i.min_last ? rarmb_pkg::StMinStore : rarmb_pkg::StMinRd;
      end
      rarmb_pkg::StMinStore: begin
        if (op_q == rarmb_pkg::OpLoad || sts_i.blk_last) state_d = rarmb_pkg::StIdle;
        else state_d = rarmb_pkg::StBlock;
      end
      rarmb_pkg::StResult: begin
        if (!out_full_q || out_ready_i) state_d = rarmb_pkg::StIdle;
      end
      default: state_d = rarmb_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      rarmb_pkg::StClear: cmd_o.clr_step = 1'b1;
      rarmb_pkg::StIdle: begin
        in_ready_o      = 1'b1;
        cmd_o.capture   = in_valid_i;
        cmd_o.res_clear = in_valid_i;
      end
      rarmb_pkg::StBlock: begin
        if (sts_i.op_valid) begin
          if (op_q == rarmb_pkg::OpLoad) begin
            cmd_o.load_write = 1'b1;
            cmd_o.min_start  = 1'b1;
          end else if (sts_i.blk_is_whole) begin
            cmd_o.blk_whole = 1'b1;
            cmd_o.blk_next  = 1'b1;
          end else begin
            cmd_o.blk_part = 1'b1;
          end
        end
      end
      rarmb_pkg::StScanRd: cmd_o.scan_rd = 1'b1;
      rarmb_pkg::StScanDo: begin
        cmd_o.scan_do = 1'b1;
        if (sts_i.scan_last) begin
          if (op_q == rarmb_pkg::OpAdd) cmd_o.min_start = 1'b1;
          else cmd_o.blk_next = 1'b1;
        end
      end
      rarmb_pkg::StMinRd: cmd_o.min_rd = 1'b1;
      rarmb_pkg::StMinDo: cmd_o.min_do = 1'b1;
      rarmb_pkg::StMinStore: begin
        cmd_o.min_store = 1'b1;
        cmd_o.blk_next  = (op_q != rarmb_pkg::OpLoad);
      end
      rarmb_pkg::StResult: cmd_o.res_load = !out_full_q || out_ready_i;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/rarmb_dpath.sv =====
// Datapath: element memory, block tables, index arithmetic and min folding.
module rarmb_dpath #(
  parameter int unsigned NumElements = rarmb_pkg::NumElementsDefault,
  parameter int unsigned BlockLen    = rarmb_pkg::BlockLenDefault,
  parameter int unsigned NumBlocks   = rarmb_pkg::NumBlocksDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        opcode_i,
  input  logic [rarmb_pkg::IdxW-1:0]        first_index_i,
  input  logic [rarmb_pkg::IdxW-1:0]        last_index_i,
  input  logic signed [rarmb_pkg::OperW-1:0] operand_value_i,
  output logic signed [rarmb_pkg::ValW-1:0] range_minimum_o,
  input  rarmb_pkg::cmd_t                   cmd_i,
  output rarmb_pkg::sts_t                   sts_o
);

  localparam int unsigned Cap   = (NumBlocks * BlockLen < NumElements) ?
                                  NumBlocks * BlockLen : NumElements;
  localparam int unsigned UsedBlocks = (Cap + BlockLen - 1) / BlockLen;
  localparam int unsigned AW    = (Cap > 1) ? $clog2(Cap) : 1;
  localparam int unsigned BW    = (UsedBlocks > 1) ? $clog2(UsedBlocks) : 1;
  localparam int unsigned WW    = 18; // wide enough for indices and Cap
  localparam int unsigned VW    = rarmb_pkg::ValW;
  localparam logic [WW-1:0] CapW  = WW'(Cap);
  localparam logic [WW-1:0] BlenW = WW'(BlockLen);
  // Block index by reciprocal multiply, exact for every index of IdxW bits.
  localparam int unsigned DivSh = rarmb_pkg::IdxW + $clog2(BlockLen);
  localparam longint unsigned DivMulL = ((64'd1 << DivSh) + 64'(BlockLen) - 64'd1) /
                                        64'(BlockLen);
  localparam logic [31:0] DivMul = 32'(DivMulL);

  logic [VW-1:0] mem_q [Cap];
  logic [VW-1:0] rd_q;
  logic [VW-1:0] offs_q [UsedBlocks];
  logic [VW-1:0] bmin_q [UsedBlocks];

  logic [WW-1:0] first_q, last_q, blk_s_q, blk_e_q, addr_q, hi_q;
  logic [BW-1:0] blk_q, blk_last_q;
  logic [VW-1:0] oper_q, acc_q, bmin_run_q, res_q;
  logic          op_valid_q, add_mode_q;
  logic [WW-1:0] clr_q;

  // Input index handling: clip last, decide emptiness, block bounds.
  logic [WW-1:0] first_w, last_w, last_clip;
  logic          in_valid_range;
  logic [WW-1:0] blk_start_w, blk_end_w;
  logic [VW-1:0] oper_ext;

  function automatic logic [BW-1:0] blk_of(input logic [rarmb_pkg::IdxW-1:0] x);
    logic [31:0] p;
    p = 32'(x) * DivMul;
    return BW'(p >> DivSh);
  endfunction

  assign first_w   = WW'(first_index_i);
  assign last_w    = WW'(last_index_i);
  assign last_clip = (last_w >= CapW) ? CapW - 1'b1 : last_w;
  assign oper_ext  = VW'(operand_value_i);
  assign in_valid_range = (opcode_i == rarmb_pkg::OpLoad) ? (first_w < CapW) :
                          ((first_w < CapW) && (first_w <= last_clip));

  // Block bounds for current block (constant BlockLen multiply).
  assign blk_start_w = WW'(blk_q) * BlenW;
  assign blk_end_w   = (blk_start_w + BlenW - 1'b1 < CapW - 1'b1) ?
                       blk_start_w + BlenW - 1'b1 : CapW - 1'b1;

  logic is_whole;
  assign is_whole = (blk_start_w >= first_q) && (blk_end_w <= last_q);

  logic [VW-1:0] cur_offs, elem_eff, elem_sum;
  assign cur_offs = offs_q[blk_q];
  assign elem_eff = rd_q + cur_offs;
  assign elem_sum = rd_q + oper_q;

  function automatic logic less_s(input logic [VW-1:0] a, input logic [VW-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  assign sts_o.clr_done     = (clr_q == CapW - 1'b1);
  assign sts_o.op_valid     = op_valid_q;
  assign sts_o.blk_is_whole = is_whole;
  assign sts_o.blk_last     = (blk_q == blk_last_q);
  assign sts_o.scan_last    = (addr_q == hi_q);
  assign sts_o.min_last     = (addr_q == blk_e_q);

  assign range_minimum_o = res_q;

  // Element memory: one write and one registered read a cycle.
  logic          we;
  logic [AW-1:0] waddr;
  logic [VW-1:0] wdata;
  always_comb begin
    we    = 1'b0;
    waddr = addr_q[AW-1:0];
    wdata = elem_sum;
    if (cmd_i.clr_step) begin
      we = 1'b1; waddr = clr_q[AW-1:0]; wdata = '0;
    end else if (cmd_i.load_write) begin
      we = 1'b1; waddr = first_q[AW-1:0]; wdata = oper_q;
    end else if (cmd_i.scan_do && add_mode_q) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (cmd_i.scan_rd || cmd_i.min_rd) rd_q <= mem_q[addr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step && !sts_o.clr_done) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Output register for a finished query minimum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (cmd_i.res_load) begin
      res_q <= acc_q;
    end
  end

  // Block tables are small enough for flip-flops with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < int'(UsedBlocks); b++) begin
        offs_q[b] <= '0;
        bmin_q[b] <= '0;
      end
    end else begin
      if (cmd_i.blk_whole && add_mode_q) offs_q[blk_q] <= cur_offs + oper_q;
      if (cmd_i.min_store) bmin_q[blk_q] <= bmin_run_q;
    end
  end

  logic [VW-1:0] whole_v;
  assign whole_v = bmin_q[blk_q] + cur_offs;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      first_q    <= first_w;
      last_q     <= last_clip;
      oper_q     <= oper_ext;
      op_valid_q <= in_valid_range;
      add_mode_q <= (opcode_i == rarmb_pkg::OpAdd);
      blk_q      <= blk_of(first_index_i);
      blk_last_q <= blk_of(last_clip[rarmb_pkg::IdxW-1:0]);
    end else begin
      if (cmd_i.blk_next && !sts_o.blk_last) blk_q <= blk_q + 1'b1;
      if (cmd_i.blk_part) begin
        addr_q <= (blk_start_w > first_q) ? blk_start_w : first_q;
        hi_q   <= (blk_end_w < last_q) ? blk_end_w : last_q;
      end else if (cmd_i.min_start) begin
        addr_q     <= blk_start_w;
        blk_e_q    <= blk_end_w;
        bmin_run_q <= '0;
      end else if (cmd_i.scan_do || cmd_i.min_do) begin
        addr_q <= addr_q + 1'b1;
      end
      if (cmd_i.min_do) begin
        if (addr_q == blk_s_q || less_s(rd_q, bmin_run_q)) bmin_run_q <= rd_q;
      end
      if (cmd_i.min_start) blk_s_q <= blk_start_w;
    end
    if (cmd_i.res_clear) acc_q <= rarmb_pkg::QueryStart;
    else if (!add_mode_q) begin
      if (cmd_i.blk_whole && less_s(whole_v, acc_q)) acc_q <= whole_v;
      if (cmd_i.scan_do && less_s(elem_eff, acc_q)) acc_q <= elem_eff;
    end
  end

endmodule

// ===== hw/rtl/range_add_range_min_blocks.sv =====
// Top level: range add and range minimum over a blocked element store.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | opcode, first/last index, operand
//  out     | output    | out_valid_o/out_ready_i| range_minimum (queries only)
//
// One item at a time; every item is taken in the idle state.
// A load then writes the element, reads, waits on and folds each element of
// its block to recompute the block minimum, and stores that minimum.
// A range add or query walks the covered blocks: a whole block is applied
// from the block tables; a partial block is set up, then each element in
// range is read, waited on and acted on; an add then recomputes its minimum.
// A query then hands its minimum to the output register.
// After reset the element memory is cleared, one entry a cycle, over all Cap
// entries (1024 by default); no item is taken meanwhile.
// A result holds in the output register until taken while the next item
// proceeds; a later query waits in its handover state while that register is full and not taken.
module range_add_range_min_blocks #(
  parameter int unsigned NumElements = rarmb_pkg::NumElementsDefault,
  parameter int unsigned BlockLen    = rarmb_pkg::BlockLenDefault,
  parameter int unsigned NumBlocks   = rarmb_pkg::NumBlocksDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         opcode_i,
  input  logic [9:0]                         first_index_i,
  input  logic [9:0]                         last_index_i,
  input  logic signed [34:0]                 operand_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [63:0]                 range_minimum_o
);

  rarmb_pkg::cmd_t cmd;
  rarmb_pkg::sts_t sts;

  // Sequence each item through the datapath.
  rarmb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold element memory, block offsets and block minima.
  rarmb_dpath #(
    .NumElements (NumElements),
    .BlockLen    (BlockLen),
    .NumBlocks   (NumBlocks)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .opcode_i        (opcode_i),
    .first_index_i   (first_index_i),
    .last_index_i    (last_index_i),
    .operand_value_i (operand_value_i),
    .range_minimum_o (range_minimum_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

// ===== hw/rtl/rarmb_checker.sv =====
// Checker: port-level properties of the top level, bound to it.
module rarmb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  opcode_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] range_minimum_o
);

  // Handshake outputs are always known.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_ready_o, out_valid_o})) else $error("handshake output unknown");

  // Result holds while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(range_minimum_o))
    else $error("result changed while stalled");

  // A result never exceeds the query start value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $signed(range_minimum_o) <= $signed(rarmb_pkg::QueryStart))
    else $error("result above start value");

  // A taken item with a real opcode keeps the input closed next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i != rarmb_pkg::OpNone |=> !in_ready_o)
    else $error("input open while item in flight");

endmodule

bind range_add_range_min_blocks rarmb_checker u_rarmb_checker (.*);

// ===== dv/range_add_range_min_blocks_tb.sv =====
// Self-checking testbench for the blocked range-add / range-minimum store.
module range_add_range_min_blocks_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumItems   = 1750;
  localparam int unsigned TailItems  = 200;   // no idling over the last stretch
  localparam int unsigned IdleLimit  = 8000;  // clear pass plus the longest add, with margin
  localparam int unsigned DrainWait  = 600;   // longest add that causes no result
  localparam int unsigned Cap        = 1024;
  localparam int unsigned BlkLen     = 32;
  localparam int unsigned NumBlk     = 32;
  localparam int unsigned NumRows    = 20;
  localparam longint      OperMax    = 64'sd10000000000;
  localparam logic [63:0] EmptyMin   = rarmb_pkg::QueryStart;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        opcode_i;
  logic [9:0]        first_index_i;
  logic [9:0]        last_index_i;
  logic signed [34:0] operand_value_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic signed [63:0] range_minimum_o;

  range_add_range_min_blocks uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .first_index_i,
    .last_index_i, .operand_value_i, .out_valid_o, .out_ready_i, .range_minimum_o
  );

  // Clock: 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the block state: raw elements, pending offsets, raw block minima.
  logic [63:0] shadow_elem [Cap];
  logic [63:0] shadow_offs [NumBlk];
  logic [63:0] shadow_bmin [NumBlk];

  logic [63:0] pending_minima [$];
  int unsigned fail_count = 0;
  bit          tail_phase = 1'b0;

  function automatic void refresh_block_min(int unsigned blk);
    logic [63:0] m;
    m = shadow_elem[blk*BlkLen];
    for (int unsigned i = blk*BlkLen + 1; i < (blk+1)*BlkLen; i++)
      if ($signed(shadow_elem[i]) < $signed(m)) m = shadow_elem[i];
    shadow_bmin[blk] = m;
  endfunction

  // Apply one item to the shadow state; return 1 with the minimum for a query.
  function automatic bit apply_item(rarmb_pkg::opcode_e op, int unsigned lo, int unsigned hi,
                                    logic [34:0] amount, output logic [63:0] minimum);
    logic [63:0] amt;
    logic [63:0] v;
    int unsigned bs, be, a, z;
    amt = {{29{amount[34]}}, amount};
    minimum = EmptyMin;
    case (op)
      rarmb_pkg::OpLoad: begin
        shadow_elem[lo] = amt;
        refresh_block_min(lo / BlkLen);
        return 1'b0;
      end
      rarmb_pkg::OpNone: return 1'b0;
      default: begin
        if (lo <= hi) begin
          for (int unsigned b = lo / BlkLen; b <= hi / BlkLen; b++) begin
            bs = b * BlkLen;
            be = bs + BlkLen - 1;
            if (bs >= lo && be <= hi) begin
              if (op == rarmb_pkg::OpAdd) shadow_offs[b] += amt;
              else begin
                v = shadow_bmin[b] + shadow_offs[b];
                if ($signed(v) < $signed(minimum)) minimum = v;
              end
            end else begin
              a = (bs > lo) ? bs : lo;
              z = (be < hi) ? be : hi;
              for (int unsigned i = a; i <= z; i++) begin
                if (op == rarmb_pkg::OpAdd) shadow_elem[i] += amt;
                else begin
                  v = shadow_elem[i] + shadow_offs[b];
                  if ($signed(v) < $signed(minimum)) minimum = v;
                end
              end
              if (op == rarmb_pkg::OpAdd) refresh_block_min(b);
            end
          end
        end
        return op == rarmb_pkg::OpQuery;
      end
    endcase
  endfunction

  // Directed rows; known marks a typed-in expected minimum.
  typedef struct {
    rarmb_pkg::opcode_e op;
    int unsigned lo;
    int unsigned hi;
    longint      amount;
    bit          known;
    logic [63:0] minimum;
  } stim_row_t;

  stim_row_t directed_rows [NumRows] = '{
    '{rarmb_pkg::OpQuery, 0,    1023, 0,          1'b1, 64'd0},      // all zero after reset
    '{rarmb_pkg::OpQuery, 5,    3,    0,          1'b1, EmptyMin},   // empty range
    '{rarmb_pkg::OpLoad,  0,    0,    OperMax,    1'b0, 64'd0},
    '{rarmb_pkg::OpLoad,  1023, 77,   -OperMax,   1'b0, 64'd0},
    '{rarmb_pkg::OpQuery, 0,    0,    0,          1'b1, 64'd10000000000},
    '{rarmb_pkg::OpQuery, 1023, 1023, 0,          1'b1, -64'sd10000000000},
    '{rarmb_pkg::OpAdd,   0,    1023, OperMax,    1'b0, 64'd0},      // every block whole
    '{rarmb_pkg::OpAdd,   3,    40,   -1,         1'b0, 64'd0},      // two partial blocks
    '{rarmb_pkg::OpAdd,   70,   20,   12345,      1'b0, 64'd0},      // empty add does nothing
    '{rarmb_pkg::OpNone,  1023, 0,    -1,         1'b0, 64'd0},      // ignored opcode
    '{rarmb_pkg::OpQuery, 0,    1023, 0,          1'b0, 64'd0},
    '{rarmb_pkg::OpQuery, 3,    40,   0,          1'b0, 64'd0},
    '{rarmb_pkg::OpAdd,   31,   96,   -OperMax,   1'b0, 64'd0},      // partial, whole, whole, partial
    '{rarmb_pkg::OpQuery, 32,   95,   0,          1'b0, 64'd0},
    '{rarmb_pkg::OpQuery, 30,   97,   0,          1'b0, 64'd0},
    '{rarmb_pkg::OpLoad,  500,  0,    -64'sd17179869184, 1'b0, 64'd0}, // 35-bit negative extreme
    '{rarmb_pkg::OpLoad,  501,  0,    64'sd17179869183,  1'b0, 64'd0}, // 35-bit positive extreme
    '{rarmb_pkg::OpQuery, 480,  511,  0,          1'b0, 64'd0},
    '{rarmb_pkg::OpQuery, 1023, 0,    0,          1'b1, EmptyMin},
    '{rarmb_pkg::OpQuery, 0,    1023, 0,          1'b0, 64'd0}
  };

  function automatic longint pick_amount();
    longint r;
    case ($urandom_range(0, 9))
      0: return OperMax;
      1: return -OperMax;
      2: return longint'($urandom_range(0, 3)) - 2;
      default: begin
        r = longint'($urandom_range(0, 19999)) * 1000000 + $urandom_range(0, 999999) - OperMax;
        return (r > OperMax) ? OperMax : r;
      end
    endcase
  endfunction

  // Offer one item, hold it until taken, then update the shadow state.
  task automatic send_item(rarmb_pkg::opcode_e op, int unsigned lo, int unsigned hi,
                           longint amount, bit known, logic [63:0] typed_min);
    logic [63:0] pred;
    bit          has_result;
    if (!tail_phase && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    first_index_i   <= lo[9:0];
    last_index_i    <= hi[9:0];
    operand_value_i <= amount[34:0];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    has_result = apply_item(op, lo, hi, amount[34:0], pred);
    if (has_result) pending_minima.push_back(known ? typed_min : pred);
  endtask

  // Result side: random stall bursts, compare each taken item with the oldest prediction.
  initial begin
    int unsigned stall_left;
    logic [63:0] want;
    stall_left  = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_minima.size() == 0) begin
          $error("range_minimum: unexpected result %0d", range_minimum_o);
          fail_count++;
        end else begin
          want = pending_minima.pop_front();
          if (range_minimum_o !== want) begin
            $error("range_minimum: expected %0d, actual %0d", $signed(want), range_minimum_o);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) stall_left--;
      else if (!tail_phase && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 3);
      out_ready_i <= (stall_left == 0);
    end
  end

  // Watchdog: count cycles in which no item moves on either side.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Stimulus: directed table, then random items.
  initial begin
    int unsigned lo, hi, span;
    rarmb_pkg::opcode_e op;
    int unsigned pick;
    in_valid_i      = 1'b0;
    opcode_i        = rarmb_pkg::OpNone;
    first_index_i   = '0;
    last_index_i    = '0;
    operand_value_i = '0;
    rst_ni          = 1'b0;
    for (int unsigned i = 0; i < Cap; i++) shadow_elem[i] = '0;
    for (int unsigned b = 0; b < NumBlk; b++) begin
      shadow_offs[b] = '0;
      shadow_bmin[b] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r])
      send_item(directed_rows[r].op, directed_rows[r].lo, directed_rows[r].hi,
                directed_rows[r].amount, directed_rows[r].known, directed_rows[r].minimum);

    for (int unsigned n = 0; n < NumItems; n++) begin
      if (n >= NumItems - TailItems) tail_phase = 1'b1;
      pick = $urandom_range(0, 99);
      op = (pick < 30) ? rarmb_pkg::OpLoad : (pick < 60) ? rarmb_pkg::OpAdd :
           (pick < 97) ? rarmb_pkg::OpQuery : rarmb_pkg::OpNone;
      lo = $urandom_range(0, Cap - 1);
      // Most ranges stay short so partial-block scans dominate without stalling the run.
      pick = $urandom_range(0, 99);
      if (pick < 50)      span = $urandom_range(0, 40);
      else if (pick < 80) span = $urandom_range(0, 200);
      else                span = Cap;
      if (pick >= 95) hi = $urandom_range(0, Cap - 1);   // may fall before the start
      else hi = (lo + span > Cap - 1) ? Cap - 1 : lo + span;
      send_item(op, lo, hi, pick_amount(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_minima.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0 && pending_minima.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
